[hw/rtl/msvpr_pkg.sv]
`timescale 1ns / 1ps

package msvpr_pkg;

	// Operand widths fixed by the interface fields
	localparam int unsigned MEAS_W  = 16;
	localparam int unsigned INTEG_W = 26;
	localparam int unsigned TERM_W  = 27;
	localparam int unsigned DUTY_W  = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 3;

	localparam int unsigned IN_DATA_W  = 88;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [INTEG_W-1:0] INTEGRAL_CAP = '1;
	localparam logic [DUTY_W-1:0]  DUTY_SAT     = '1;

	// Loop gains and fixed step sizes
	localparam logic signed [TERM_W-1:0] GAIN_I          = 27'sd2;
	localparam logic signed [TERM_W-1:0] GAIN_P          = 27'sd5;
	localparam logic signed [TERM_W-1:0] IOUT_MIN_FACTOR = 27'sd5;
	localparam logic signed [TERM_W-1:0] VIN_FACTOR      = 27'sd2;
	localparam logic signed [TERM_W-1:0] TRACK_SCALE     = 27'sd1000;
	localparam logic signed [TERM_W-1:0] FREE_RUN_STEP   = 27'sd1000000;

	typedef enum logic [2:0] {
		LIMIT_OFF      = 3'd0,
		LIMIT_VOUT_MAX = 3'd1,
		LIMIT_IOUT_MAX = 3'd2,
		LIMIT_IOUT_MIN = 3'd3,
		LIMIT_VIN_MIN  = 3'd4,
		LIMIT_VIN_MAX  = 3'd5
	} limit_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MPPT_MODE = 3'd0,
		REG_VOUT_MAX  = 3'd1,
		REG_IOUT_MAX  = 3'd2,
		REG_IOUT_MIN  = 3'd3,
		REG_VIN_MIN   = 3'd4,
		REG_VIN_MAX   = 3'd5,
		REG_DUTY_MAX  = 3'd6,
		REG_VIN_LOST  = 3'd7
	} reg_idx_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_STEP  = 1'b1
	} action_t;

	function automatic logic signed [TERM_W-1:0] ext_u16(input logic [MEAS_W-1:0] v);
		return $signed({{(TERM_W-MEAS_W){1'b0}}, v});
	endfunction

	function automatic logic signed [TERM_W-1:0] ext_s16(input logic signed [MEAS_W-1:0] v);
		return $signed({{(TERM_W-MEAS_W){v[MEAS_W-1]}}, v});
	endfunction

endpackage

[hw/rtl/min_select_velocity_pi_regulator_core.sv]
`timescale 1ns / 1ps

// Min-select velocity PI duty regulator, one request per control tick.
//
// Input stream (s_*): s_tuser is the action (0 start, 1 step), s_tdata holds the
// measurements and tracker step. A start loads the duty integral from start_duty,
// records vout/iout and clears the active limit. A step takes the minimum of a
// baseline increment and five limit terms, holds the winning limit for HOLD_STEPS
// steps, adds the minimum to the integral and clamps it to 0 .. duty_max scaled.
// Output stream (m_*): duty (integral / INTEGRAL_SCALE), active limit, input-lost.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only idle.
//
// Pipeline: a request reaches m_tvalid through three registers (input
// register, update stage with the min select and clamp, output stage with the
// divide by the scale done as a reciprocal multiply). Throughput: one request
// per cycle while m_tready is high; the state is written as a request leaves the
// input register, so each request sees the previous one.
// When m_tready is low the pipeline fills and then holds; s_tready drops only
// once all three stages are full, and no result is lost or repeated.
// Reset clears the config registers to their defaults, the integral, the saved
// measurements, the limit hold and all valid flags; no clearing pass is needed.
module min_select_velocity_pi_regulator_core #(
	parameter int unsigned HOLD_STEPS     = 100,
	parameter int unsigned INTEGRAL_SCALE = 1000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] start_duty, [31:16] vin_mv, [47:32] vout_mv, [63:48] iout_ma,
	// [64] track_tick, [80:65] track_delta, [87:81] zero
	input  logic [msvpr_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] action
	input  logic                                s_tuser,
	// result channel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] duty, [18:16] active_limit, [19] input_lost, [23:20] zero
	output logic [msvpr_pkg::OUT_DATA_W-1:0]    m_tdata,
	// configuration
	input  logic                                cfg_we,
	input  logic [msvpr_pkg::IDX_W-1:0]         cfg_index,
	input  logic [msvpr_pkg::CFG_W-1:0]         cfg_data
);

	localparam int unsigned HOLD_W    = $clog2(HOLD_STEPS + 1);
	// Reciprocal for the output divide: exact for every integral value
	localparam int unsigned DIV_SHIFT = msvpr_pkg::INTEG_W + $clog2(INTEGRAL_SCALE);
	localparam longint unsigned DIV_MULT =
		((64'd1 << DIV_SHIFT) + 64'(INTEGRAL_SCALE) - 64'd1) / 64'(INTEGRAL_SCALE);
	localparam int unsigned MULT_W    = msvpr_pkg::INTEG_W + 1;
	localparam int unsigned PROD_W    = msvpr_pkg::INTEG_W + MULT_W;

	localparam int unsigned MW = msvpr_pkg::MEAS_W;
	localparam int unsigned TW = msvpr_pkg::TERM_W;
	localparam int unsigned IW = msvpr_pkg::INTEG_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic                 mppt_mode_q;
	logic [MW-1:0]        vout_max_q;
	logic [14:0]          iout_max_q;
	logic signed [MW-1:0] iout_min_q;
	logic [MW-1:0]        vin_min_q;
	logic [MW-1:0]        vin_max_q;
	logic [MW-1:0]        duty_max_q;
	logic [MW-1:0]        vin_lost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mppt_mode_q <= 1'b0;
			vout_max_q  <= '0;
			iout_max_q  <= '0;
			iout_min_q  <= 16'sh8000;
			vin_min_q   <= '0;
			vin_max_q   <= '1;
			duty_max_q  <= '0;
			vin_lost_q  <= '0;
		end else if (cfg_we) begin
			unique case (msvpr_pkg::reg_idx_t'(cfg_index))
				msvpr_pkg::REG_MPPT_MODE: mppt_mode_q <= cfg_data[0];
				msvpr_pkg::REG_VOUT_MAX:  vout_max_q  <= cfg_data;
				msvpr_pkg::REG_IOUT_MAX:  iout_max_q  <= cfg_data[14:0];
				msvpr_pkg::REG_IOUT_MIN:  iout_min_q  <= $signed(cfg_data);
				msvpr_pkg::REG_VIN_MIN:   vin_min_q   <= cfg_data;
				msvpr_pkg::REG_VIN_MAX:   vin_max_q   <= cfg_data;
				msvpr_pkg::REG_DUTY_MAX:  duty_max_q  <= cfg_data;
				msvpr_pkg::REG_VIN_LOST:  vin_lost_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline handshake: each stage advances when the next one frees up
	// ------------------------------------------------------------------
	logic v1_q, v2_q, v3_q;
	logic load2, load3;

	assign load3    = v2_q && (!v3_q || m_tready);
	assign load2    = v1_q && (!v2_q || load3);
	assign s_tready = !v1_q || load2;
	assign m_tvalid = v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (s_tready) v1_q <= s_tvalid;
			if (!v2_q || load3) v2_q <= v1_q;
			if (!v3_q || m_tready) v3_q <= v2_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic                 action_s1;
	logic [MW-1:0]        start_duty_s1;
	logic [MW-1:0]        vin_s1;
	logic [MW-1:0]        vout_s1;
	logic signed [MW-1:0] iout_s1;
	logic                 tick_s1;
	logic signed [MW-1:0] delta_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1     <= s_tuser;
			start_duty_s1 <= s_tdata[15:0];
			vin_s1        <= s_tdata[31:16];
			vout_s1       <= s_tdata[47:32];
			iout_s1       <= $signed(s_tdata[63:48]);
			tick_s1       <= s_tdata[64];
			delta_s1      <= $signed(s_tdata[80:65]);
		end
	end

	// ------------------------------------------------------------------
	// Regulator state
	// ------------------------------------------------------------------
	logic [IW-1:0]               integral_q;
	logic [MW-1:0]               prev_vout_q;
	logic signed [MW-1:0]        prev_iout_q;
	msvpr_pkg::limit_t           limit_q;
	logic [HOLD_W-1:0]           hold_q;

	// Update-stage combinational signals
	logic [31:0]                 cap_full;
	logic [IW-1:0]               cap;
	logic [31:0]                 start_full;
	logic [IW-1:0]               start_integ;
	logic signed [TW-1:0]        baseline;
	logic signed [TW-1:0]        t_vout, t_iout, t_imin, t_vmin, t_vmax;
	logic signed [TW-1:0]        d_imin, d_vmin, d_vmax;
	logic signed [TW-1:0]        best;
	logic signed [TW:0]          sum;
	logic [IW-1:0]               step_integ;
	logic [HOLD_W-1:0]           hold_dec;
	logic [HOLD_W-1:0]           hold_nxt;
	msvpr_pkg::limit_t           limit_nxt;
	logic [IW-1:0]               integ_nxt;
	msvpr_pkg::limit_t           out_limit;
	logic                        lost;

	// Scaled duty_max (the clamp bound) and scaled start duty saturate at the cap
	assign cap_full    = 32'(duty_max_q) * 32'(INTEGRAL_SCALE);
	assign cap         = (cap_full > 32'(msvpr_pkg::INTEGRAL_CAP)) ?
		msvpr_pkg::INTEGRAL_CAP : cap_full[IW-1:0];
	assign start_full  = 32'(start_duty_s1) * 32'(INTEGRAL_SCALE);
	assign start_integ = (start_full > 32'(msvpr_pkg::INTEGRAL_CAP)) ?
		msvpr_pkg::INTEGRAL_CAP : start_full[IW-1:0];

	assign lost = (vin_s1 < vin_lost_q);

	// Velocity PI terms for the two ceilings, scaled integral terms otherwise
	assign t_vout = msvpr_pkg::GAIN_I *
			(msvpr_pkg::ext_u16(vout_max_q) - msvpr_pkg::ext_u16(vout_s1))
		- msvpr_pkg::GAIN_P *
			(msvpr_pkg::ext_u16(vout_s1) - msvpr_pkg::ext_u16(prev_vout_q));
	assign t_iout = msvpr_pkg::GAIN_I *
			(msvpr_pkg::ext_u16({1'b0, iout_max_q}) - msvpr_pkg::ext_s16(iout_s1))
		- msvpr_pkg::GAIN_P *
			(msvpr_pkg::ext_s16(iout_s1) - msvpr_pkg::ext_s16(prev_iout_q));

	assign d_imin = msvpr_pkg::ext_s16(iout_s1) - msvpr_pkg::ext_s16(iout_min_q);
	assign d_vmin = msvpr_pkg::ext_u16(vin_s1) - msvpr_pkg::ext_u16(vin_min_q);
	assign d_vmax = msvpr_pkg::ext_u16(vin_max_q) - msvpr_pkg::ext_u16(vin_s1);
	assign t_imin = msvpr_pkg::GAIN_I * d_imin * msvpr_pkg::IOUT_MIN_FACTOR;
	assign t_vmin = msvpr_pkg::GAIN_I * d_vmin * msvpr_pkg::VIN_FACTOR;
	assign t_vmax = msvpr_pkg::GAIN_I * d_vmax * msvpr_pkg::VIN_FACTOR;

	always_comb begin
		if (!mppt_mode_q) begin
			baseline = msvpr_pkg::FREE_RUN_STEP;
		end else if (tick_s1) begin
			baseline = msvpr_pkg::ext_s16(delta_s1) * msvpr_pkg::TRACK_SCALE;
		end else begin
			baseline = '0;
		end
	end

	// Ordered min select: a term wins only when strictly smaller
	always_comb begin
		hold_dec  = (hold_q != '0) ? hold_q - HOLD_W'(1) : hold_q;
		limit_nxt = (hold_dec == '0) ? msvpr_pkg::LIMIT_OFF : limit_q;
		hold_nxt  = hold_dec;
		best      = baseline;

		if (t_vout < best) begin
			best = t_vout;
			if (!mppt_mode_q || t_vout[TW-1] || t_vout == '0) begin
				limit_nxt = msvpr_pkg::LIMIT_VOUT_MAX;
				hold_nxt  = HOLD_W'(HOLD_STEPS);
			end
		end
		if (t_iout < best) begin
			best = t_iout;
			if (!mppt_mode_q || t_iout[TW-1] || t_iout == '0) begin
				limit_nxt = msvpr_pkg::LIMIT_IOUT_MAX;
				hold_nxt  = HOLD_W'(HOLD_STEPS);
			end
		end
		if (d_imin[TW-1] && t_imin < best) begin
			best      = t_imin;
			limit_nxt = msvpr_pkg::LIMIT_IOUT_MIN;
			hold_nxt  = HOLD_W'(HOLD_STEPS);
		end
		if (d_vmin[TW-1] && t_vmin < best) begin
			best      = t_vmin;
			limit_nxt = msvpr_pkg::LIMIT_VIN_MIN;
			hold_nxt  = HOLD_W'(HOLD_STEPS);
		end
		if (d_vmax[TW-1] && t_vmax < best) begin
			best      = t_vmax;
			limit_nxt = msvpr_pkg::LIMIT_VIN_MAX;
			hold_nxt  = HOLD_W'(HOLD_STEPS);
		end
	end

	// Integrate and clamp to 0 .. cap
	assign sum = $signed({2'b00, integral_q}) + $signed({best[TW-1], best});

	always_comb begin
		if (sum[TW]) begin
			step_integ = '0;
		end else if (sum > $signed({2'b00, cap})) begin
			step_integ = cap;
		end else begin
			step_integ = sum[IW-1:0];
		end
	end

	assign integ_nxt = (action_s1 == msvpr_pkg::ACT_START) ? start_integ : step_integ;
	assign out_limit = (action_s1 == msvpr_pkg::ACT_START) ? msvpr_pkg::LIMIT_OFF :
		limit_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q  <= '0;
			prev_vout_q <= '0;
			prev_iout_q <= '0;
			limit_q     <= msvpr_pkg::LIMIT_OFF;
			hold_q      <= '0;
		end else if (load2) begin
			integral_q  <= integ_nxt;
			prev_vout_q <= vout_s1;
			prev_iout_q <= iout_s1;
			limit_q     <= out_limit;
			// a start leaves the hold counter alone
			if (action_s1 == msvpr_pkg::ACT_STEP) hold_q <= hold_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: updated integral and flags
	// ------------------------------------------------------------------
	logic [IW-1:0]     integral_s2;
	msvpr_pkg::limit_t limit_s2;
	logic              lost_s2;

	always_ff @(posedge clk) begin
		if (load2) begin
			integral_s2 <= integ_nxt;
			limit_s2    <= out_limit;
			lost_s2     <= lost;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: divide by the scale through a reciprocal multiply, saturate
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] div_prod;
	logic [PROD_W-1:0] quo;
	logic [msvpr_pkg::DUTY_W-1:0] duty;

	assign div_prod = PROD_W'(integral_s2) * PROD_W'(MULT_W'(DIV_MULT));
	assign quo      = div_prod >> DIV_SHIFT;
	assign duty     = (quo > PROD_W'(msvpr_pkg::DUTY_SAT)) ? msvpr_pkg::DUTY_SAT :
		quo[msvpr_pkg::DUTY_W-1:0];

	always_ff @(posedge clk) begin
		if (load3) begin
			m_tdata <= {4'b0000, lost_s2, limit_s2, duty};
		end
	end

`ifndef ASSERT_OFF
	// A latched limit always has hold time left
	a_limit_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(limit_q != msvpr_pkg::LIMIT_OFF) |-> (hold_q != '0))
		else $error("active limit with expired hold counter");

	// A request taken in moves into the input register
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v1_q)
		else $error("accepted request lost at input register");

	// A blocked update stage keeps its integral
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !load3) |=> (v2_q && $stable(integral_s2)))
		else $error("stalled update stage changed");

	// A loaded output is presented on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load3 |=> m_tvalid)
		else $error("result loaded but not presented");
`endif

endmodule
